>>> design/atoirp_pkg.sv
`timescale 1ns / 1ps

package atoirp_pkg;

  // Radix codes as reported on the result channel.
  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_OCT = 2'd2,
    RX_BIN = 2'd3
  } radix_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_H  = 8'h48;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_UC_O  = 8'h4F;
  localparam logic [7:0] CH_LC_O  = 8'h6F;
  localparam logic [7:0] CH_UC_B  = 8'h42;
  localparam logic [7:0] CH_LC_B  = 8'h62;

  // Offsets that turn a letter into its hex digit value.
  localparam logic [7:0] LC_OFS = 8'd87;
  localparam logic [7:0] UC_OFS = 8'd55;

  // Classified character, as passed from the front end to the back end.
  typedef struct packed {
    logic       term;      // string terminator
    logic       space;     // space or tab
    logic       amp;       // ampersand
    logic       minus;
    logic       plus;
    logic       pfx_ok;    // H, O or B in either case
    radix_t     pfx_radix; // radix that the prefix letter selects
    logic       dig_ok;    // a hex digit in either case
    logic [3:0] dig_val;   // its value, 0 to 15
  } token_t;

  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

>>> design/atoirp_front.sv
`timescale 1ns / 1ps

module atoirp_front (
  input  logic              [7:0] char_code,
  output atoirp_pkg::token_t      tok
);

  logic [7:0] dig_diff;

  always_comb begin
    tok       = '0;
    dig_diff  = '0;
    tok.term  = (char_code == atoirp_pkg::CH_NUL);
    tok.space = (char_code == atoirp_pkg::CH_SPACE) || (char_code == atoirp_pkg::CH_TAB);
    tok.amp   = (char_code == atoirp_pkg::CH_AMP);
    tok.minus = (char_code == atoirp_pkg::CH_MINUS);
    tok.plus  = (char_code == atoirp_pkg::CH_PLUS);

    tok.pfx_radix = atoirp_pkg::RX_DEC;
    if ((char_code == atoirp_pkg::CH_UC_H) || (char_code == atoirp_pkg::CH_LC_H)) begin
      tok.pfx_ok    = 1'b1;
      tok.pfx_radix = atoirp_pkg::RX_HEX;
    end else if ((char_code == atoirp_pkg::CH_UC_O) || (char_code == atoirp_pkg::CH_LC_O)) begin
      tok.pfx_ok    = 1'b1;
      tok.pfx_radix = atoirp_pkg::RX_OCT;
    end else if ((char_code == atoirp_pkg::CH_UC_B) || (char_code == atoirp_pkg::CH_LC_B)) begin
      tok.pfx_ok    = 1'b1;
      tok.pfx_radix = atoirp_pkg::RX_BIN;
    end

    // The value is taken as a hex digit here; the back end checks it
    // against the radix in force.
    if ((char_code >= atoirp_pkg::CH_ZERO) && (char_code <= atoirp_pkg::CH_NINE)) begin
      tok.dig_ok = 1'b1;
      dig_diff   = char_code - atoirp_pkg::CH_ZERO;
    end else if ((char_code >= atoirp_pkg::CH_LC_A) && (char_code <= atoirp_pkg::CH_LC_F)) begin
      tok.dig_ok = 1'b1;
      dig_diff   = char_code - atoirp_pkg::LC_OFS;
    end else if ((char_code >= atoirp_pkg::CH_UC_A) && (char_code <= atoirp_pkg::CH_UC_F)) begin
      tok.dig_ok = 1'b1;
      dig_diff   = char_code - atoirp_pkg::UC_OFS;
    end
    tok.dig_val = dig_diff[3:0];
  end

endmodule

>>> design/atoirp_queue.sv
`timescale 1ns / 1ps

module atoirp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  atoirp_pkg::token_t push_tok,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output atoirp_pkg::token_t head_tok
);

  localparam int unsigned PW = $clog2(atoirp_pkg::QUEUE_DEPTH);

  atoirp_pkg::token_t   slot_r [atoirp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr_r;
  logic [PW-1:0]        rd_ptr_r;
  logic [PW:0]          count_r;
  logic [PW:0]          count_nxt;

  assign full       = (count_r == (PW+1)'(atoirp_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_tok   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

>>> design/atoirp_back.sv
`timescale 1ns / 1ps

module atoirp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tok_valid,
  input  atoirp_pkg::token_t tok,
  output logic               tok_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_parsed_value,
  output logic        [1:0]  out_radix_used
);

  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_AMP    = 3'd1,
    PH_SIGN   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_FROZEN = 3'd4
  } phase_t;

  phase_t             phase_r, phase_nxt;
  atoirp_pkg::radix_t radix_r, radix_nxt;
  logic [31:0]        accum_r, accum_nxt;
  logic               neg_r, neg_nxt;
  logic               out_valid_r;
  logic [31:0]        value_r;
  logic [1:0]         radix_out_r;

  logic               out_free;
  atoirp_pkg::radix_t dig_radix;
  logic               dig_good;
  logic [31:0]        scaled;
  logic               sign_pos;

  assign out_free = !out_valid_r || !out_stall;
  assign tok_pop  = tok_valid && (!tok.term || out_free);

  assign out_valid        = out_valid_r;
  assign out_parsed_value = value_r;
  assign out_radix_used   = radix_out_r;

  always_comb begin
    // An ampersand followed by a non-prefix character switches to octal
    // and the same character is then taken as a sign or digit.
    dig_radix = radix_r;
    if ((phase_r == PH_AMP) && !tok.pfx_ok) begin
      dig_radix = atoirp_pkg::RX_OCT;
    end

    case (dig_radix)
      atoirp_pkg::RX_HEX: begin
        dig_good = tok.dig_ok;
        scaled   = {accum_r[27:0], 4'b0};
      end
      atoirp_pkg::RX_OCT: begin
        dig_good = tok.dig_ok && (tok.dig_val < 4'd8);
        scaled   = {accum_r[28:0], 3'b0};
      end
      atoirp_pkg::RX_BIN: begin
        dig_good = tok.dig_ok && (tok.dig_val < 4'd2);
        scaled   = {accum_r[30:0], 1'b0};
      end
      default: begin
        dig_good = tok.dig_ok && (tok.dig_val < 4'd10);
        scaled   = {accum_r[28:0], 3'b0} + {accum_r[30:0], 1'b0};
      end
    endcase

    phase_nxt = phase_r;
    radix_nxt = radix_r;
    accum_nxt = accum_r;
    neg_nxt   = neg_r;
    sign_pos  = 1'b0;

    if (tok_pop) begin
      if (tok.term) begin
        phase_nxt = PH_SKIP;
        radix_nxt = atoirp_pkg::RX_DEC;
        accum_nxt = '0;
        neg_nxt   = 1'b0;
      end else begin
        case (phase_r)
          PH_SKIP: begin
            if (tok.amp) begin
              phase_nxt = PH_AMP;
            end else if (!tok.space) begin
              sign_pos = 1'b1;
            end
          end
          PH_AMP: begin
            radix_nxt = dig_radix;
            if (tok.pfx_ok) begin
              radix_nxt = tok.pfx_radix;
              phase_nxt = PH_SIGN;
            end else begin
              sign_pos = 1'b1;
            end
          end
          PH_SIGN: begin
            sign_pos = 1'b1;
          end
          PH_DIGITS: begin
            if (dig_good) begin
              accum_nxt = scaled + {28'b0, tok.dig_val};
            end else begin
              phase_nxt = PH_FROZEN;
            end
          end
          default: begin
          end
        endcase

        if (sign_pos) begin
          if (tok.minus) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_DIGITS;
          end else if (tok.plus) begin
            phase_nxt = PH_DIGITS;
          end else if (dig_good) begin
            accum_nxt = scaled + {28'b0, tok.dig_val};
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_FROZEN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SKIP;
      radix_r     <= atoirp_pkg::RX_DEC;
      accum_r     <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      accum_r <= accum_nxt;
      neg_r   <= neg_nxt;
      if (tok_pop && tok.term) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && tok.term) begin
      value_r     <= neg_r ? (32'd0 - accum_r) : accum_r;
      radix_out_r <= radix_r;
    end
  end

  a_term_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_pop && tok.term) |=> out_valid_r)
    else $error("terminator did not produce a result");

  a_term_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_pop && tok.term) |=> (phase_r == PH_SKIP && accum_r == 32'd0 && !neg_r))
    else $error("parser did not return to its start state after a terminator");

  a_neg_phase: assert property (@(posedge clk) disable iff (!rst_n)
    neg_r |-> (phase_r == PH_DIGITS || phase_r == PH_FROZEN))
    else $error("minus sign recorded outside the digit phases");

  a_radix_early: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP || phase_r == PH_AMP) |-> (radix_r == atoirp_pkg::RX_DEC))
    else $error("radix changed before the prefix was complete");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(tok_pop && tok.term))
    else $error("new result would overwrite a waiting one");

endmodule

>>> design/ascii_to_integer_radix_prefix.sv
`timescale 1ns / 1ps

// Streaming text-to-integer parser. Each input request carries one byte of a
// string and a zero byte ends it; on that terminator one result request
// carries the signed 32-bit value (wrapping modulo 2^32) and the radix that
// was applied (0 decimal, 1 hex, 2 octal, 3 binary), and the parser returns
// to its start state. Leading spaces and tabs are skipped, "&H", "&O" and
// "&B" in either case select hex, octal and binary, and an "&" followed by
// any other character selects octal and keeps that character. One optional
// sign may follow, then digits of the radix are gathered until the first
// invalid character, after which the rest of the string is ignored. The
// block takes one byte per cycle when the result side is not stalling; the
// figure is set by the shift-and-add in the back end. A result is
// registered in the back end when it takes the terminator from the queue.
// The front end classifies each byte as it is accepted and writes it into
// a two-entry queue, so input stalls only when that queue is full. A result
// waiting under stall holds the back end only at a terminator; other bytes
// keep flowing until the queue fills.

module ascii_to_integer_radix_prefix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [7:0]  in_char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_parsed_value,
  output logic        [1:0]  out_radix_used
);

  atoirp_pkg::token_t in_tok;
  atoirp_pkg::token_t head_tok;
  logic               q_full;
  logic               q_push;
  logic               head_valid;
  logic               head_pop;

  // The input side stalls only while the queue is full.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  atoirp_front u_front (
    .char_code (in_char_code),
    .tok       (in_tok)
  );

  atoirp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_tok   (in_tok),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  // The back end runs the parse state and owns the result register.
  atoirp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .tok_valid        (head_valid),
    .tok              (head_tok),
    .tok_pop          (head_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_parsed_value (out_parsed_value),
    .out_radix_used   (out_radix_used)
  );

endmodule
